/* rtl/fhd_pkg.sv */
// shared types and constants of the fire heat diffusion unit
package fhd_pkg;

   // request field widths
   localparam int KIND_W = 2;
   localparam int COL_IN_W = 6;
   localparam int ROW_IN_W = 6;
   localparam int HEAT_W = 8;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [COL_IN_W-1:0] col_in_type;
   typedef logic [ROW_IN_W-1:0] row_in_type;
   typedef logic [HEAT_W-1:0]   heat_type;

   // request kinds
   localparam kind_type KIND_WRITE = 2'd0;
   localparam kind_type KIND_STEP  = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;

   // sum of three cells fits in 10 bits (at most 765)
   localparam int SUM_W = 10;
   typedef logic [SUM_W-1:0] sum_type;

   // divide by three as multiply by reciprocal, exact for sums below 2^16
   localparam int DIV3_MUL_W = 16;
   localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 16'd43691;
   localparam int DIV3_SHIFT = 17;
   localparam int PROD_W = SUM_W + DIV3_MUL_W;

endpackage

/* rtl/fire_heat_diffusion_unit.sv */
// fire heat diffusion unit: heat frame in ram with a streaming diffusion sweep
//
// The unit holds HEIGHT visible rows plus one hidden seed row of WIDTH 8-bit
// cells in a single-write, single-read frame ram. After reset a clearing pass
// writes zero to every cell, and no request is taken until it ends. A step
// streams the frame through the ram read port one cell per cycle, row 0 first
// into a two-row line buffer, then each row below while the row above it is
// updated and written back, followed by a seed row clear. Every request
// returns one result; a result that is not yet taken holds the unit before
// it goes idle.
module fire_heat_diffusion_unit #(
   parameter int WIDTH = 64,
   parameter int HEIGHT = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fhd_pkg::kind_type   req_kind,
   input  fhd_pkg::col_in_type req_column,
   input  fhd_pkg::row_in_type req_row,
   input  fhd_pkg::heat_type   req_heat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fhd_pkg::heat_type   rsp_cell_heat
);

   import fhd_pkg::*;

   localparam int FRAME_DEPTH = (HEIGHT + 1) * WIDTH;
   localparam int FA_W = $clog2(FRAME_DEPTH);
   localparam int LB_DEPTH = 2 * WIDTH;
   localparam int LB_W = $clog2(LB_DEPTH);
   localparam int COL_W = $clog2(WIDTH);
   localparam int ROW_W = $clog2(HEIGHT + 1);
   localparam int SEED_BASE = HEIGHT * WIDTH;

   // sequencer states
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_SEED  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [FA_W-1:0]  raddr_ff, raddr_in;
   logic [COL_W-1:0] j_ff, j_in;
   logic [ROW_W-1:0] p_ff, p_in;
   logic             rd_hit_ff, rd_hit_in;
   heat_type         res_ff, res_in;

   logic             s1_live_ff, s1_live_in;
   logic             s1_comp_ff, s1_comp_in;
   logic             s1_bank_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [FA_W-1:0]  s1_waddr_ff, s1_waddr_in;
   heat_type         b1_ff, b2_ff;
   sum_type          sum_ff, sum_in;
   logic             s2_comp_ff;
   logic [FA_W-1:0]  s2_waddr_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   heat_type         rsp_cell_heat_ff, rsp_cell_heat_in;

   logic             frame_we;
   logic [FA_W-1:0]  frame_waddr;
   heat_type         frame_wdata;
   logic [FA_W-1:0]  frame_raddr;
   heat_type         frame_rdata;
   logic [LB_W-1:0]  lb_waddr;
   logic [LB_W-1:0]  lb_raddr;
   heat_type         lb_rdata;

   logic             accept;
   logic             rsp_free;
   logic             sweep_comp;
   logic [COL_W-1:0] here_col;
   logic [PROD_W-1:0] prod;
   heat_type         quot;
   heat_type         cooled;

   // line buffer address: bank selects one of two rows
   function automatic logic [LB_W-1:0] lb_addr(input logic bank, input logic [COL_W-1:0] col);
      logic [LB_W-1:0] base;
      base = bank ? LB_W'(WIDTH) : '0;
      return LB_W'(base + LB_W'(col));
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // sweep issue: compute once a row above exists and the window is full
   assign sweep_comp = (p_ff != '0) && (j_ff >= COL_W'(2));
   assign here_col = (j_ff == '0) ? '0 : COL_W'(j_ff - COL_W'(1));

   // stage two: divide by three and cool
   assign prod = PROD_W'(sum_ff) * PROD_W'(DIV3_MUL);
   assign quot = prod[DIV3_SHIFT +: HEAT_W];
   assign cooled = (quot == '0) ? '0 : heat_type'(quot - heat_type'(1));

   // sequencer and frame port selection
   always_comb begin
      state_in = state_ff;
      raddr_in = raddr_ff;
      j_in = j_ff;
      p_in = p_ff;
      rd_hit_in = rd_hit_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_heat_in = rsp_cell_heat_ff;
      frame_we = s2_comp_ff;
      frame_waddr = s2_waddr_ff;
      frame_wdata = cooled;
      frame_raddr = raddr_ff;
      s1_live_in = 1'b0;
      s1_comp_in = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            frame_we = 1'b1;
            frame_waddr = raddr_ff;
            frame_wdata = '0;
            if (raddr_ff == FA_W'(FRAME_DEPTH - 1)) begin
               raddr_in = '0;
               state_in = ST_IDLE;
            end else begin
               raddr_in = FA_W'(raddr_ff + FA_W'(1));
            end
         end
         ST_IDLE: begin
            frame_raddr = FA_W'(32'(req_row) * WIDTH + 32'(req_column));
            if (accept) begin
               res_in = '0;
               unique case (req_kind)
                  KIND_WRITE: begin
                     frame_we = (32'(req_column) < WIDTH);
                     frame_waddr = FA_W'(SEED_BASE + 32'(req_column));
                     frame_wdata = req_heat;
                     state_in = ST_DONE;
                  end
                  KIND_STEP: begin
                     raddr_in = '0;
                     j_in = '0;
                     p_in = '0;
                     state_in = ST_SWEEP;
                  end
                  KIND_READ: begin
                     rd_hit_in = (32'(req_column) < WIDTH) && (32'(req_row) <= HEIGHT);
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in = rd_hit_ff ? frame_rdata : '0;
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            s1_live_in = 1'b1;
            s1_comp_in = sweep_comp;
            if (raddr_ff == FA_W'(FRAME_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
            raddr_in = FA_W'(raddr_ff + FA_W'(1));
            if (j_ff == COL_W'(WIDTH - 1)) begin
               j_in = '0;
               p_in = ROW_W'(p_ff + ROW_W'(1));
            end else begin
               j_in = COL_W'(j_ff + COL_W'(1));
            end
         end
         ST_DRAIN: begin
            if (!s1_live_ff && !s2_comp_ff) begin
               raddr_in = FA_W'(SEED_BASE);
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            frame_we = 1'b1;
            frame_waddr = raddr_ff;
            frame_wdata = '0;
            if (raddr_ff == FA_W'(FRAME_DEPTH - 1)) begin
               state_in = ST_DONE;
            end else begin
               raddr_in = FA_W'(raddr_ff + FA_W'(1));
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cell_heat_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // stage one: below cell arrives, here cell from line buffer
   assign s1_waddr_in = FA_W'(raddr_ff - FA_W'(WIDTH + 1));
   assign sum_in = sum_type'(lb_rdata) + sum_type'(b2_ff) + sum_type'(frame_rdata);
   assign lb_raddr = lb_addr(~p_ff[0], here_col);
   assign lb_waddr = lb_addr(s1_bank_ff, s1_col_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         raddr_ff <= '0;
         s1_live_ff <= 1'b0;
         s1_comp_ff <= 1'b0;
         s2_comp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         raddr_ff <= raddr_in;
         s1_live_ff <= s1_live_in;
         s1_comp_ff <= s1_comp_in;
         s2_comp_ff <= s1_comp_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff <= j_in;
      p_ff <= p_in;
      rd_hit_ff <= rd_hit_in;
      res_ff <= res_in;
      s1_bank_ff <= p_ff[0];
      s1_col_ff <= j_ff;
      s1_waddr_ff <= s1_waddr_in;
      if (s1_live_ff) begin
         b1_ff <= frame_rdata;
         b2_ff <= b1_ff;
      end
      sum_ff <= sum_in;
      s2_waddr_ff <= s1_waddr_ff;
      rsp_cell_heat_ff <= rsp_cell_heat_in;
   end

   // heat frame, seed row last
   fhd_ram #(
      .DATA_W(HEAT_W),
      .DEPTH(FRAME_DEPTH)
   ) u_frame_ram (
      .clock(clock),
      .wr_en(frame_we),
      .wr_addr(frame_waddr),
      .wr_data(frame_wdata),
      .rd_addr(frame_raddr),
      .rd_data(frame_rdata)
   );

   // two-row line buffer of unmodified cells
   fhd_ram #(
      .DATA_W(HEAT_W),
      .DEPTH(LB_DEPTH)
   ) u_line_ram (
      .clock(clock),
      .wr_en(s1_live_ff),
      .wr_addr(lb_waddr),
      .wr_data(frame_rdata),
      .rd_addr(lb_raddr),
      .rd_data(lb_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_heat = rsp_cell_heat_ff;

endmodule

/* rtl/fhd_ram.sv */
// generic simple dual port ram with registered read
module fhd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* verif/fhd_checker.sv */
// checker for the fire heat diffusion unit: frame prediction and result compare
`timescale 1ns / 1ps

module fhd_checker #(
   parameter int WIDTH = 64,
   parameter int HEIGHT = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  fhd_pkg::kind_type   req_kind,
   input  fhd_pkg::col_in_type req_column,
   input  fhd_pkg::row_in_type req_row,
   input  fhd_pkg::heat_type   req_heat,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  fhd_pkg::heat_type   rsp_cell_heat,
   output int                  fail_count,
   output int                  pending_count
);
   import fhd_pkg::*;

   localparam int REPORT_MAX = 10;

   typedef struct {
      kind_type   kind;
      col_in_type column;
      row_in_type row;
      heat_type   cell_heat;
   } heat_expect_type;

   // own copy of the frame, row HEIGHT is the seed row
   heat_type frame_copy [0:HEIGHT][0:WIDTH-1];
   heat_expect_type expected_heat_q[$];

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   // one diffusion sweep, top row first, in place
   function automatic void diffuse_frame_copy();
      int s;
      int q;
      for (int r = 0; r < HEIGHT; r++) begin
         for (int c = 1; c + 1 < WIDTH; c++) begin
            s = int'(frame_copy[r][c]) + int'(frame_copy[r+1][c-1])
               + int'(frame_copy[r+1][c+1]);
            q = s / 3;
            if (q != 0) q = q - 1;
            frame_copy[r][c] = heat_type'(q);
         end
      end
      for (int c = 0; c < WIDTH; c++) frame_copy[HEIGHT][c] = '0;
   endfunction

   // apply one request to the frame copy and return the cell heat it gives
   function automatic heat_type predict_cell_heat(kind_type k, col_in_type col,
                                                   row_in_type row, heat_type heat);
      heat_type result;
      result = '0;
      case (k)
         KIND_WRITE: begin
            if (int'(col) < WIDTH) frame_copy[HEIGHT][col] = heat;
         end
         KIND_STEP: diffuse_frame_copy();
         KIND_READ: begin
            if (int'(col) < WIDTH && int'(row) <= HEIGHT) result = frame_copy[row][col];
         end
         default: ;
      endcase
      return result;
   endfunction

   // compare each result transfer, then predict each request transfer
   always @(posedge clock) begin
      heat_expect_type exp_item;
      if (reset) begin
         for (int r = 0; r <= HEIGHT; r++)
            for (int c = 0; c < WIDTH; c++) frame_copy[r][c] = '0;
         expected_heat_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_heat_q.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("unexpected rsp transfer, cell_heat %0d", rsp_cell_heat);
               fail_count = fail_count + 1;
            end else begin
               exp_item = expected_heat_q.pop_front();
               if (rsp_cell_heat !== exp_item.cell_heat) begin
                  if (fail_count < REPORT_MAX)
                     $display("mismatch: kind %0d col %0d row %0d expected %0d actual %0d",
                              exp_item.kind, exp_item.column, exp_item.row,
                              exp_item.cell_heat, rsp_cell_heat);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            exp_item.kind = req_kind;
            exp_item.column = req_column;
            exp_item.row = req_row;
            exp_item.cell_heat = predict_cell_heat(req_kind, req_column, req_row, req_heat);
            expected_heat_q.push_back(exp_item);
         end
      end
      pending_count = expected_heat_q.size();
   end

endmodule

/* verif/fire_heat_diffusion_unit_tb.sv */
// testbench top of the fire heat diffusion unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module fire_heat_diffusion_unit_tb;
   import fhd_pkg::*;

   localparam int WIDTH = 64;
   localparam int HEIGHT = 32;
   localparam int RANDOM_ITEMS = 265;
   localparam int IDLE_PCT = 12;
   localparam int CALM_FIRST = 120;
   localparam int CALM_LAST = 190;
   // the watchdog limit exceeds a step sweep and the clearing pass after reset
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 50;
   localparam kind_type KIND_UNUSED = 2'd3;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   kind_type   req_kind = KIND_READ;
   col_in_type req_column = '0;
   row_in_type req_row = '0;
   heat_type   req_heat = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   heat_type   rsp_cell_heat;

   int fail_count;
   int pending_count;
   int random_sent = 0;
   logic calm = 1'b0;
   logic accepted;

   fire_heat_diffusion_unit #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_column(req_column),
      .req_row(req_row),
      .req_heat(req_heat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_heat(rsp_cell_heat)
   );

   fhd_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_column(req_column),
      .req_row(req_row),
      .req_heat(req_heat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_heat(rsp_cell_heat),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side stalls at random outside the calm stretch
   always @(posedge clock) begin
      if (calm) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
   end

   assign accepted = (req_valid && req_ready) || (rsp_valid && rsp_ready);

   // watchdog on cycles without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (accepted) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
      end
      $display("== FAIL ==");
      $finish;
   end

   // present one request and return at the edge of its transfer
   task automatic send_request(kind_type k, col_in_type col, row_in_type row, heat_type heat);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_column <= col;
      req_row <= row;
      req_heat <= heat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(kind_type k, col_in_type col, row_in_type row, heat_type heat);
      send_request(k, col, row, heat);
      random_sent = random_sent + 1;
      calm <= (random_sent >= CALM_FIRST && random_sent < CALM_LAST);
   endtask

   // seed writes, usually a step, then reads biased toward the bottom rows, and occasional noise
   task automatic run_burst();
      int n_writes;
      int n_reads;
      int n_noise;
      int pick;
      heat_type heat;
      row_in_type row;
      n_writes = $urandom_range(1, 8);
      for (int i = 0; i < n_writes; i++) begin
         if ($urandom_range(0, 99) < 70) heat = heat_type'($urandom_range(128, 255));
         else heat = heat_type'($urandom_range(0, 255));
         send_random(KIND_WRITE, col_in_type'($urandom_range(0, 63)),
                     row_in_type'($urandom_range(0, 63)), heat);
      end
      if ($urandom_range(0, 99) < 75)
         send_random(KIND_STEP, col_in_type'($urandom_range(0, 63)),
                     row_in_type'($urandom_range(0, 63)), heat_type'($urandom_range(0, 255)));
      n_reads = $urandom_range(2, 6);
      for (int i = 0; i < n_reads; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) row = row_in_type'($urandom_range(HEIGHT - 6, HEIGHT));
         else if (pick < 90) row = row_in_type'($urandom_range(0, HEIGHT));
         else row = row_in_type'($urandom_range(HEIGHT + 1, 63));
         send_random(KIND_READ, col_in_type'($urandom_range(0, 63)), row,
                     heat_type'($urandom_range(0, 255)));
      end
      // occasional fully random noise
      if ($urandom_range(0, 99) < 15) begin
         n_noise = $urandom_range(1, 3);
         for (int i = 0; i < n_noise; i++)
            send_random(kind_type'($urandom_range(0, 3)), col_in_type'($urandom_range(0, 63)),
                        row_in_type'($urandom_range(0, 63)), heat_type'($urandom_range(0, 255)));
      end
   endtask

   // main sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty frame, seed extremes, out of range reads, unused kind
      send_request(KIND_READ, 6'd0, 6'd0, 8'd0);
      send_request(KIND_READ, 6'd63, 6'd32, 8'd255);
      send_request(KIND_WRITE, 6'd0, 6'd0, 8'd255);
      send_request(KIND_WRITE, 6'd63, 6'd63, 8'd255);
      send_request(KIND_WRITE, 6'd1, 6'd5, 8'd255);
      send_request(KIND_WRITE, 6'd2, 6'd0, 8'd255);
      send_request(KIND_WRITE, 6'd3, 6'd0, 8'd170);
      send_request(KIND_READ, 6'd0, 6'd32, 8'd0);
      send_request(KIND_READ, 6'd3, 6'd32, 8'd0);
      send_request(KIND_READ, 6'd5, 6'd33, 8'd0);
      send_request(KIND_READ, 6'd63, 6'd63, 8'd0);
      send_request(KIND_UNUSED, 6'd63, 6'd63, 8'd255);
      // step: edge columns stay, seed row clears
      send_request(KIND_STEP, 6'd0, 6'd0, 8'd0);
      send_request(KIND_READ, 6'd0, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd1, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd2, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd63, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd1, 6'd32, 8'd0);
      // second step lifts heat one row, zero quotient case
      send_request(KIND_WRITE, 6'd40, 6'd0, 8'd0);
      send_request(KIND_WRITE, 6'd5, 6'd0, 8'd1);
      send_request(KIND_STEP, 6'd63, 6'd63, 8'd255);
      send_request(KIND_READ, 6'd2, 6'd30, 8'd0);
      send_request(KIND_READ, 6'd1, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd4, 6'd31, 8'd0);
      send_request(KIND_READ, 6'd6, 6'd31, 8'd0);

      // random bursts
      while (random_sent < RANDOM_ITEMS) run_burst();
      req_valid <= 1'b0;
      calm <= 1'b0;

      // drain, once the checker has seen the last request transfer and every result
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
